FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Checks that a consequent holds whenever an antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/core/a2ab_pkg.sv
`timescale 1ns / 1ps

package a2ab_pkg;

    localparam logic [1:0] FMT_BYTE_STREAM = 2'd0;
    localparam logic [1:0] FMT_AVCC        = 2'd1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_TRUNC_PREFIX = 2'd1;
    localparam logic [1:0] ST_OVERRUN      = 2'd2;
    localparam logic [1:0] ST_UNSUPPORTED  = 2'd3;

    localparam logic [2:0] PHASE_LAST_PREFIX = 3'd3;
    localparam logic [2:0] PHASE_PAYLOAD     = 3'd4;

    localparam int MAX_RESULTS = 4;
    localparam int QUEUE_DEPTH = 8;

    typedef struct packed
    {
        logic [7:0] in_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       buffer_done;
        logic [1:0] status;
    } out_item_t;

    function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
        logic [7:0] b;
        b = (idx == 2'd3) ? 8'h01 : 8'h00;
        return b;
    endfunction

endpackage

FILE: rtl/core/avcc_to_annexb_converter.sv
`timescale 1ns / 1ps
// Results of an accepted request are registered into the queue behind any older results.
// Throughput: one request per cycle while in_stall is low; results leave the 8-entry
// queue at one per cycle while out_stall is low. in_stall is high while the queue holds
// more than four results, so a start-code burst of four results is always absorbed.
// Reset: rst_n clears the queue and the prefix state and sets the format to AVCC.
`include "assert_macros.svh"

module avcc_to_annexb_converter
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  a2ab_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output a2ab_pkg::out_item_t out_data
);
    import a2ab_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]       fmt_reg;
    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [31:0]      rem_reg;
    logic [31:0]      rem_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    out_item_t        queue_mem [QUEUE_DEPTH];

    out_item_t        res [MAX_RESULTS];
    logic [2:0]       n_res;
    logic             push;
    logic             pop;
    logic             in_prefix;
    logic [2:0]       eff_phase;
    logic [31:0]      shifted;
    logic [31:0]      dec;

    assign in_stall  = count_reg > CNT_W'(QUEUE_DEPTH - MAX_RESULTS);
    assign out_valid = count_reg != '0;
    assign out_data  = queue_mem[head_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    // A payload phase with nothing left to send is taken as a fresh prefix.
    assign in_prefix = (phase_reg != PHASE_PAYLOAD) || (rem_reg == '0);
    assign eff_phase = (phase_reg == PHASE_PAYLOAD) ? 3'd0 : phase_reg;
    assign shifted   = (phase_reg == PHASE_PAYLOAD) ? {24'd0, in_data.in_byte}
                                                    : {rem_reg[23:0], in_data.in_byte};
    assign dec       = rem_reg - 32'd1;

    always_comb
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            res[k] = '{out_byte: start_code_byte(2'(k)), has_byte: 1'b1,
                       buffer_done: 1'b0, status: ST_OK};
        end
        n_res      = 3'd0;
        phase_next = 3'd0;
        rem_next   = '0;
        if (fmt_reg == FMT_BYTE_STREAM)
        begin
            res[0] = '{out_byte: in_data.in_byte, has_byte: 1'b1,
                       buffer_done: in_data.buffer_end, status: ST_OK};
            n_res  = 3'd1;
        end
        else if (fmt_reg != FMT_AVCC)
        begin
            res[0] = '{out_byte: 8'd0, has_byte: 1'b0, buffer_done: 1'b1,
                       status: ST_UNSUPPORTED};
            n_res  = in_data.buffer_end ? 3'd1 : 3'd0;
        end
        else if (in_prefix)
        begin
            if (in_data.buffer_end)
            begin
                res[0] = '{out_byte: 8'd0, has_byte: 1'b0, buffer_done: 1'b1,
                           status: ST_TRUNC_PREFIX};
                n_res  = 3'd1;
            end
            else if (eff_phase != PHASE_LAST_PREFIX)
            begin
                phase_next = eff_phase + 3'd1;
                rem_next   = shifted;
            end
            else
            begin
                n_res      = 3'd4;
                phase_next = (shifted == '0) ? 3'd0 : PHASE_PAYLOAD;
                rem_next   = shifted;
            end
        end
        else
        begin
            res[0] = '{out_byte: in_data.in_byte, has_byte: 1'b1,
                       buffer_done: 1'b0, status: ST_OK};
            n_res  = 3'd1;
            if (dec == '0)
            begin
                res[0].buffer_done = in_data.buffer_end;
            end
            else if (in_data.buffer_end)
            begin
                res[1] = '{out_byte: 8'd0, has_byte: 1'b0, buffer_done: 1'b1,
                           status: ST_OVERRUN};
                n_res  = 3'd2;
            end
            else
            begin
                phase_next = PHASE_PAYLOAD;
                rem_next   = dec;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            count_next = count_next + CNT_W'(n_res);
        end
        if (pop)
        begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_AVCC;
            phase_reg <= 3'd0;
            rem_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fmt_reg <= cfg_wr_data;
            end
            if (push)
            begin
                phase_reg <= phase_next;
                rem_reg   <= rem_next;
                tail_reg  <= tail_reg + IDX_W'(n_res);
            end
            if (pop)
            begin
                head_reg <= head_reg + IDX_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                if (3'(k) < n_res)
                begin
                    queue_mem[tail_reg + IDX_W'(k)] <= res[k];
                end
            end
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
    `ASSERT_ALWAYS(a_phase_range, clk, rst_n, phase_reg <= PHASE_PAYLOAD, "phase out of range")
    `ASSERT_IMPLIES(a_payload_nonzero, clk, rst_n, phase_reg == PHASE_PAYLOAD, rem_reg != '0, "payload phase with zero remaining")
    `ASSERT_IMPLIES(a_queue_tracks, clk, rst_n, count_reg != '0, tail_reg == head_reg + IDX_W'(count_reg), "queue pointers disagree with count")

endmodule
